/* hdl/bagate_pkg.sv */
// ----------------------------------------------------------------------------
// bagate_pkg
// Shared types, widths and codes for the barometer altitude spike gate.
// ----------------------------------------------------------------------------
package bagate_pkg;

    localparam int SDATA_W = 96;
    localparam int SUSER_W = 1;
    localparam int MDATA_W = 144;
    localparam int MUSER_W = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 20;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PRESSURE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PRESSURE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATE        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GATE_DT_MAX     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REJECT_LIMIT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_INTERVAL = 3'd5;

    // result status codes
    localparam logic [3:0] STATUS_DISABLED     = 4'd0;
    localparam logic [3:0] STATUS_TOO_SOON     = 4'd1;
    localparam logic [3:0] STATUS_TRIG_FAILED  = 4'd2;
    localparam logic [3:0] STATUS_NO_READING   = 4'd3;
    localparam logic [3:0] STATUS_OUT_OF_RANGE = 4'd4;
    localparam logic [3:0] STATUS_SPIKE        = 4'd5;
    localparam logic [3:0] STATUS_ACCEPTED     = 4'd6;
    localparam logic [3:0] STATUS_RESEEDED     = 4'd7;
    localparam logic [3:0] STATUS_REINIT       = 4'd8;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_REINIT = 1'b1;

    typedef struct packed {
        logic [16:0] min_pressure_pa;
        logic [16:0] max_pressure_pa;
        logic [19:0] max_rate_cm_per_s;
        logic [15:0] gate_dt_max_ms;
        logic [7:0]  reject_run_limit;
        logic [15:0] sample_interval_ms;
    } cfg_t;

    typedef struct packed {
        logic               req_type;
        logic [31:0]        now_ms;
        logic               sensor_ok;
        logic               trigger_ok;
        logic [16:0]        pressure_pa;
        logic signed [14:0] temperature_centi;
        logic signed [23:0] altitude_cm;
    } sample_t;

    typedef struct packed {
        logic [3:0]         status;
        logic signed [23:0] pub_altitude_cm;
        logic [16:0]        pub_pressure_pa;
        logic signed [14:0] pub_temperature_centi;
        logic               reseed_flag;
        logic [31:0]        spike_total;
        logic [31:0]        trigger_fail_total;
        logic signed [23:0] spike_altitude_cm;
    } result_t;

endpackage

/* hdl/baro_altitude_spike_gate.sv */
// ----------------------------------------------------------------------------
// baro_altitude_spike_gate
// Qualifies barometer samples: interval gate, trigger count, zero drop,
// pressure window and altitude rate gate with reseed after a rejection run.
//
//   channel  direction  per transfer
//   s_*      in         one sample or reinit request
//   m_*      out        one status result per request
//   cfg_*    in         one register write, no read-back
//
// An item passes through the input and result registers; a new item is
// taken every cycle unless m_ stalls. History state advances as an
// item moves into the result register, so the next item sees it at once.
// Reset clears history and loads register defaults. A stalled m_ side
// holds the result and backs up through the input register to s_tready.
// ----------------------------------------------------------------------------
module baro_altitude_spike_gate (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // now_ms, sensor_ok, trigger_ok, pressure_pa, temperature_centi, altitude_cm
    input  logic [bagate_pkg::SDATA_W-1:0]     s_tdata,
    // req_type
    input  logic [bagate_pkg::SUSER_W-1:0]     s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // pub_altitude_cm, pub_pressure_pa, pub_temperature_centi, spike_total,
    // trigger_fail_total, spike_altitude_cm
    output logic [bagate_pkg::MDATA_W-1:0]     m_tdata,
    // status, reseed_flag
    output logic [bagate_pkg::MUSER_W-1:0]     m_tuser,
    input  logic                               cfg_we,
    input  logic [bagate_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bagate_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    bagate_pkg::cfg_t    cfg;
    bagate_pkg::sample_t item;
    bagate_pkg::result_t res;
    logic                item_valid;
    logic                res_ready;
    logic                fire;

    assign fire = item_valid && res_ready;

    bagate_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bagate_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_valid (item_valid),
        .item_take  (res_ready),
        .item       (item)
    );

    bagate_qualify u_qualify (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .fire    (fire),
        .item    (item),
        .result  (res)
    );

    bagate_out_stage u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (item_valid),
        .res_ready (res_ready),
        .res       (res),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

/* hdl/bagate_cfg_regs.sv */
// ----------------------------------------------------------------------------
// bagate_cfg_regs
// Configuration register file written through a plain write port.
// ----------------------------------------------------------------------------
module bagate_cfg_regs (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [bagate_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bagate_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output bagate_pkg::cfg_t                     cfg
);

    bagate_pkg::cfg_t cfg_reg;
    bagate_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                bagate_pkg::CFG_MIN_PRESSURE:    cfg_next.min_pressure_pa    = cfg_wdata[16:0];
                bagate_pkg::CFG_MAX_PRESSURE:    cfg_next.max_pressure_pa    = cfg_wdata[16:0];
                bagate_pkg::CFG_MAX_RATE:        cfg_next.max_rate_cm_per_s  = cfg_wdata;
                bagate_pkg::CFG_GATE_DT_MAX:     cfg_next.gate_dt_max_ms     = cfg_wdata[15:0];
                bagate_pkg::CFG_REJECT_LIMIT:    cfg_next.reject_run_limit   = cfg_wdata[7:0];
                bagate_pkg::CFG_SAMPLE_INTERVAL: cfg_next.sample_interval_ms = cfg_wdata[15:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_pressure_pa    <= 17'd30000;
            cfg_reg.max_pressure_pa    <= 17'd110000;
            cfg_reg.max_rate_cm_per_s  <= 20'd50000;
            cfg_reg.gate_dt_max_ms     <= 16'd500;
            cfg_reg.reject_run_limit   <= 8'd5;
            cfg_reg.sample_interval_ms <= 16'd50;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hdl/bagate_in_stage.sv */
// ----------------------------------------------------------------------------
// bagate_in_stage
// Input register: unpacks a sample transfer and holds it until taken.
// ----------------------------------------------------------------------------
module bagate_in_stage (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [bagate_pkg::SDATA_W-1:0]     s_tdata,
    input  logic [bagate_pkg::SUSER_W-1:0]     s_tuser,
    output logic                               item_valid,
    input  logic                               item_take,
    output bagate_pkg::sample_t                item
);

    logic                valid_reg;
    logic                valid_next;
    bagate_pkg::sample_t item_reg;
    bagate_pkg::sample_t item_next;

    assign s_tready = !valid_reg || item_take;

    always_comb begin
        valid_next = s_tready ? s_tvalid : valid_reg;
        item_next.req_type          = s_tuser[0];
        item_next.now_ms            = s_tdata[31:0];
        item_next.sensor_ok         = s_tdata[32];
        item_next.trigger_ok        = s_tdata[33];
        item_next.pressure_pa       = s_tdata[50:34];
        item_next.temperature_centi = s_tdata[65:51];
        item_next.altitude_cm       = s_tdata[89:66];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* hdl/bagate_qualify.sv */
// ----------------------------------------------------------------------------
// bagate_qualify
// Check chain and history state; state advances as an item is taken.
// ----------------------------------------------------------------------------
module bagate_qualify (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  bagate_pkg::cfg_t     cfg,
    input  logic                 fire,
    input  bagate_pkg::sample_t  item,
    output bagate_pkg::result_t  result
);

    logic [31:0]        last_read_time_reg,   last_read_time_next;
    logic signed [23:0] last_good_alt_reg,    last_good_alt_next;
    logic [31:0]        last_good_time_reg,   last_good_time_next;
    logic               seeded_reg,           seeded_next;
    logic [7:0]         reject_run_reg,       reject_run_next;
    logic [31:0]        spike_cnt_reg,        spike_cnt_next;
    logic [31:0]        trig_fail_cnt_reg,    trig_fail_cnt_next;
    logic signed [23:0] spike_alt_reg,        spike_alt_next;
    logic signed [23:0] pub_alt_reg,          pub_alt_next;
    logic [16:0]        pub_press_reg,        pub_press_next;
    logic signed [14:0] pub_temp_reg,         pub_temp_next;

    logic [31:0]        since_read;
    logic [31:0]        dt_raw;
    logic [15:0]        dt_clamp;
    logic signed [24:0] alt_diff;
    logic [24:0]        alt_mag;
    logic [34:0]        step_scaled;
    logic [35:0]        step_allowed;
    logic [7:0]         run_inc;
    logic               too_soon;
    logic               out_of_range;
    logic               is_spike;
    logic [3:0]         status;
    logic               reseed;

    assign since_read   = item.now_ms - last_read_time_reg;
    assign too_soon     = since_read < {16'd0, cfg.sample_interval_ms};
    assign out_of_range = (item.pressure_pa < cfg.min_pressure_pa)
                       || (item.pressure_pa > cfg.max_pressure_pa);
    assign dt_raw       = item.now_ms - last_good_time_reg;
    assign dt_clamp     = (dt_raw > {16'd0, cfg.gate_dt_max_ms}) ? cfg.gate_dt_max_ms
                                                                 : dt_raw[15:0];
    assign alt_diff     = {item.altitude_cm[23], item.altitude_cm}
                        - {last_good_alt_reg[23], last_good_alt_reg};
    assign alt_mag      = alt_diff[24] ? 25'(-alt_diff) : 25'(alt_diff);
    assign step_scaled  = 35'(alt_mag) * 35'd1000;
    assign step_allowed = 36'(cfg.max_rate_cm_per_s) * 36'(dt_clamp);
    assign is_spike     = {1'b0, step_scaled} > step_allowed;
    assign run_inc      = reject_run_reg + 8'd1;

    always_comb begin
        last_read_time_next = last_read_time_reg;
        last_good_alt_next  = last_good_alt_reg;
        last_good_time_next = last_good_time_reg;
        seeded_next         = seeded_reg;
        reject_run_next     = reject_run_reg;
        spike_cnt_next      = spike_cnt_reg;
        trig_fail_cnt_next  = trig_fail_cnt_reg;
        spike_alt_next      = spike_alt_reg;
        pub_alt_next        = pub_alt_reg;
        pub_press_next      = pub_press_reg;
        pub_temp_next       = pub_temp_reg;
        status              = bagate_pkg::STATUS_DISABLED;
        reseed              = 1'b0;

        if (item.req_type == bagate_pkg::REQ_REINIT) begin
            seeded_next         = 1'b0;
            reject_run_next     = 8'd0;
            last_good_time_next = item.now_ms;
            status              = bagate_pkg::STATUS_REINIT;
        end else if (!item.sensor_ok) begin
            status = bagate_pkg::STATUS_DISABLED;
        end else if (too_soon) begin
            status = bagate_pkg::STATUS_TOO_SOON;
        end else begin
            last_read_time_next = item.now_ms;
            if (!item.trigger_ok) begin
                trig_fail_cnt_next = trig_fail_cnt_reg + 32'd1;
                status             = bagate_pkg::STATUS_TRIG_FAILED;
            end else if (item.pressure_pa == 17'd0) begin
                status = bagate_pkg::STATUS_NO_READING;
            end else if (out_of_range) begin
                spike_cnt_next = spike_cnt_reg + 32'd1;
                status         = bagate_pkg::STATUS_OUT_OF_RANGE;
            end else if (seeded_reg && is_spike && (run_inc < cfg.reject_run_limit)) begin
                spike_cnt_next  = spike_cnt_reg + 32'd1;
                spike_alt_next  = item.altitude_cm;
                reject_run_next = run_inc;
                status          = bagate_pkg::STATUS_SPIKE;
            end else begin
                if (seeded_reg && is_spike) begin
                    // run limit reached: take the value and reseed
                    spike_cnt_next = spike_cnt_reg + 32'd1;
                    spike_alt_next = item.altitude_cm;
                    reseed         = 1'b1;
                end
                reject_run_next     = 8'd0;
                last_good_alt_next  = item.altitude_cm;
                last_good_time_next = item.now_ms;
                seeded_next         = 1'b1;
                pub_alt_next        = item.altitude_cm;
                pub_press_next      = item.pressure_pa;
                pub_temp_next       = item.temperature_centi;
                status              = reseed ? bagate_pkg::STATUS_RESEEDED
                                             : bagate_pkg::STATUS_ACCEPTED;
            end
        end

        result.status                = status;
        result.pub_altitude_cm       = pub_alt_next;
        result.pub_pressure_pa       = pub_press_next;
        result.pub_temperature_centi = pub_temp_next;
        result.reseed_flag           = reseed;
        result.spike_total           = spike_cnt_next;
        result.trigger_fail_total    = trig_fail_cnt_next;
        result.spike_altitude_cm     = spike_alt_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_read_time_reg <= 32'd0;
            last_good_alt_reg  <= 24'sd0;
            last_good_time_reg <= 32'd0;
            seeded_reg         <= 1'b0;
            reject_run_reg     <= 8'd0;
            spike_cnt_reg      <= 32'd0;
            trig_fail_cnt_reg  <= 32'd0;
            spike_alt_reg      <= 24'sd0;
            pub_alt_reg        <= 24'sd0;
            pub_press_reg      <= 17'd0;
            pub_temp_reg       <= 15'sd0;
        end else if (fire) begin
            last_read_time_reg <= last_read_time_next;
            last_good_alt_reg  <= last_good_alt_next;
            last_good_time_reg <= last_good_time_next;
            seeded_reg         <= seeded_next;
            reject_run_reg     <= reject_run_next;
            spike_cnt_reg      <= spike_cnt_next;
            trig_fail_cnt_reg  <= trig_fail_cnt_next;
            spike_alt_reg      <= spike_alt_next;
            pub_alt_reg        <= pub_alt_next;
            pub_press_reg      <= pub_press_next;
            pub_temp_reg       <= pub_temp_next;
        end
    end

endmodule

/* hdl/bagate_out_stage.sv */
// ----------------------------------------------------------------------------
// bagate_out_stage
// Result register: holds one result and packs it onto the master side.
// ----------------------------------------------------------------------------
module bagate_out_stage (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               res_valid,
    output logic                               res_ready,
    input  bagate_pkg::result_t                res,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [bagate_pkg::MDATA_W-1:0]     m_tdata,
    output logic [bagate_pkg::MUSER_W-1:0]     m_tuser
);

    logic                valid_reg;
    logic                valid_next;
    bagate_pkg::result_t res_reg;

    assign res_ready  = !valid_reg || m_tready;
    assign valid_next = res_ready ? res_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = {res_reg.reseed_flag, res_reg.status};
    assign m_tdata  = {res_reg.spike_altitude_cm,
                       res_reg.trigger_fail_total,
                       res_reg.spike_total,
                       res_reg.pub_temperature_centi,
                       res_reg.pub_pressure_pa,
                       res_reg.pub_altitude_cm};

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the barometer altitude spike gate. A short directed
// run walks every status code, the time wrap and a full rejection run ending
// in a reseed. Random samples then run under several register settings,
// the extremes among them, with random gaps on both stream sides. A
// scoreboard predicts each result from its own copy of the gate state and
// checks every field of every result transfer.
// ----------------------------------------------------------------------------
module tb_top;
    import bagate_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    class gate_scoreboard;
        cfg_t               cfg = '{17'd30000, 17'd110000, 20'd50000, 16'd500, 8'd5, 16'd50};
        logic [31:0]        read_time = '0;
        logic [31:0]        good_time = '0;
        logic signed [23:0] good_alt = '0;
        logic               seeded = 1'b0;
        logic [7:0]         run = '0;
        logic [31:0]        spike_cnt = '0;
        logic [31:0]        trig_cnt = '0;
        logic signed [23:0] spike_alt = '0;
        logic signed [23:0] pub_alt = '0;
        logic [16:0]        pub_pa = '0;
        logic [14:0]        pub_temp = '0;
        result_t            due[$];
        int                 errors = 0;

        function void set_config(cfg_t c);
            cfg = c;
        endfunction

        function int pending();
            return due.size();
        endfunction

        function void note_input(sample_t it);
            result_t            r;
            logic [3:0]         st;
            logic [31:0]        elapsed;
            logic [31:0]        dt;
            logic signed [23:0] alt;
            longint             diff;
            longint unsigned    mag;
            longint unsigned    allowed;
            alt = it.altitude_cm;
            elapsed = it.now_ms - read_time;
            if (it.req_type == REQ_REINIT) begin
                seeded = 1'b0;
                run = '0;
                good_time = it.now_ms;
                st = STATUS_REINIT;
            end else if (!it.sensor_ok) begin
                st = STATUS_DISABLED;
            end else if (elapsed < {16'd0, cfg.sample_interval_ms}) begin
                st = STATUS_TOO_SOON;
            end else begin
                read_time = it.now_ms;
                if (!it.trigger_ok) begin
                    trig_cnt = trig_cnt + 32'd1;
                    st = STATUS_TRIG_FAILED;
                end else if (it.pressure_pa == '0) begin
                    st = STATUS_NO_READING;
                end else if (it.pressure_pa < cfg.min_pressure_pa ||
                             it.pressure_pa > cfg.max_pressure_pa) begin
                    spike_cnt = spike_cnt + 32'd1;
                    st = STATUS_OUT_OF_RANGE;
                end else begin
                    st = STATUS_ACCEPTED;
                    if (seeded) begin
                        dt = it.now_ms - good_time;
                        if (dt > {16'd0, cfg.gate_dt_max_ms})
                            dt = {16'd0, cfg.gate_dt_max_ms};
                        diff = longint'(alt) - longint'(good_alt);
                        mag = (diff < 0) ? -diff : diff;
                        allowed = longint'(cfg.max_rate_cm_per_s) * longint'(dt);
                        if (mag * 64'd1000 > allowed) begin
                            spike_cnt = spike_cnt + 32'd1;
                            spike_alt = alt;
                            run = run + 8'd1;
                            st = (run < cfg.reject_run_limit) ? STATUS_SPIKE : STATUS_RESEEDED;
                        end
                    end
                    if (st != STATUS_SPIKE) begin
                        run = '0;
                        good_alt = alt;
                        good_time = it.now_ms;
                        seeded = 1'b1;
                        pub_alt = alt;
                        pub_pa = it.pressure_pa;
                        pub_temp = it.temperature_centi;
                    end
                end
            end
            r.status = st;
            r.pub_altitude_cm = pub_alt;
            r.pub_pressure_pa = pub_pa;
            r.pub_temperature_centi = pub_temp;
            r.reseed_flag = (st == STATUS_RESEEDED);
            r.spike_total = spike_cnt;
            r.trigger_fail_total = trig_cnt;
            r.spike_altitude_cm = spike_alt;
            due.push_back(r);
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result transfer: expected none, got %h", $time, got);
                return;
            end
            want = due.pop_front();
            check_field("status", want.status, got.status);
            check_field("pub_altitude_cm", want.pub_altitude_cm, got.pub_altitude_cm);
            check_field("pub_pressure_pa", want.pub_pressure_pa, got.pub_pressure_pa);
            check_field("pub_temperature_centi", want.pub_temperature_centi,
                        got.pub_temperature_centi);
            check_field("reseed_flag", want.reseed_flag, got.reseed_flag);
            check_field("spike_total", want.spike_total, got.spike_total);
            check_field("trigger_fail_total", want.trigger_fail_total, got.trigger_fail_total);
            check_field("spike_altitude_cm", want.spike_altitude_cm, got.spike_altitude_cm);
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [SDATA_W-1:0]     s_tdata = '0;
    logic [SUSER_W-1:0]     s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [MDATA_W-1:0]     m_tdata;
    logic [MUSER_W-1:0]     m_tuser;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    gate_scoreboard sb = new;
    int unsigned    cycles = 0;
    int unsigned    send_count = 0;
    int             send_idle_pct = 0;
    int             recv_stall_pct = 0;

    baro_altitude_spike_gate dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver: random stalls, with stall-free stretches
    always @(posedge aclk) begin
        result_t got;
        m_tready <= ($urandom_range(0, 99) >= ((cycles % 300 < 60) ? 0 : recv_stall_pct));
        if (aresetn && m_tvalid && m_tready) begin
            got.status = m_tuser[3:0];
            got.reseed_flag = m_tuser[4];
            got.pub_altitude_cm = m_tdata[23:0];
            got.pub_pressure_pa = m_tdata[40:24];
            got.pub_temperature_centi = m_tdata[55:41];
            got.spike_total = m_tdata[87:56];
            got.trigger_fail_total = m_tdata[119:88];
            got.spike_altitude_cm = m_tdata[143:120];
            sb.check_result(got);
        end
    end

    function automatic sample_t mk(logic req, logic [31:0] now, logic ok, logic trig,
                                   int pa, int temp, int alt);
        sample_t it;
        it.req_type = req;
        it.now_ms = now;
        it.sensor_ok = ok;
        it.trigger_ok = trig;
        it.pressure_pa = 17'(pa);
        it.temperature_centi = 15'(temp);
        it.altitude_cm = 24'(alt);
        return it;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] reg_value(cfg_t c, logic [CFG_IDX_W-1:0] idx);
        case (idx)
            CFG_MIN_PRESSURE:    return CFG_DATA_W'(c.min_pressure_pa);
            CFG_MAX_PRESSURE:    return CFG_DATA_W'(c.max_pressure_pa);
            CFG_MAX_RATE:        return c.max_rate_cm_per_s;
            CFG_GATE_DT_MAX:     return CFG_DATA_W'(c.gate_dt_max_ms);
            CFG_REJECT_LIMIT:    return CFG_DATA_W'(c.reject_run_limit);
            default:             return CFG_DATA_W'(c.sample_interval_ms);
        endcase
    endfunction

    // mostly well-formed samples tracking the gate's history, plus broken ones
    function automatic sample_t gen_random();
        sample_t         it;
        cfg_t            c;
        int unsigned     pick;
        logic [31:0]     dt;
        longint unsigned bound;
        longint          step;
        c = sb.cfg;
        pick = $urandom_range(0, 99);
        it = '0;
        it.req_type = REQ_SAMPLE;
        it.sensor_ok = 1'b1;
        it.trigger_ok = 1'b1;
        it.now_ms = sb.read_time + {16'd0, c.sample_interval_ms} + $urandom_range(0, 300);
        if ($urandom_range(0, 9) < 8)
            it.temperature_centi = 15'(int'($urandom_range(0, 12500)) - 4000);
        else
            it.temperature_centi = 15'($urandom);
        if (c.min_pressure_pa <= c.max_pressure_pa)
            it.pressure_pa = 17'($urandom_range(c.min_pressure_pa, c.max_pressure_pa));
        else
            it.pressure_pa = 17'($urandom_range(1, 131071));
        dt = it.now_ms - sb.good_time;
        if (dt > {16'd0, c.gate_dt_max_ms})
            dt = {16'd0, c.gate_dt_max_ms};
        bound = (longint'(c.max_rate_cm_per_s) * longint'(dt)) / 1000;
        case ($urandom_range(0, 9))
            0:       step = bound;
            1:       step = -longint'(bound);
            2, 3:    step = longint'(bound) + 1 + $urandom_range(0, 500000);
            4:       step = -longint'(bound) - 1 - $urandom_range(0, 500000);
            default: step = longint'($urandom_range(0, 32'(2 * bound))) - longint'(bound);
        endcase
        it.altitude_cm = 24'(longint'(sb.good_alt) + step);

        if (pick >= 60 && pick < 68) begin
            if (c.sample_interval_ms != '0)
                it.now_ms = sb.read_time + $urandom_range(0, c.sample_interval_ms - 1);
        end else if (pick >= 68 && pick < 73) begin
            it.sensor_ok = 1'b0;
            it.now_ms = $urandom;
        end else if (pick >= 73 && pick < 77) begin
            it.trigger_ok = 1'b0;
        end else if (pick >= 77 && pick < 80) begin
            it.pressure_pa = '0;
        end else if (pick >= 80 && pick < 86) begin
            if ($urandom_range(0, 1) && c.min_pressure_pa > 17'd1)
                it.pressure_pa = 17'($urandom_range(1, c.min_pressure_pa - 1));
            else if (c.max_pressure_pa < 17'h1FFFF)
                it.pressure_pa = 17'($urandom_range(c.max_pressure_pa + 1, 131071));
            else if (c.min_pressure_pa > 17'd1)
                it.pressure_pa = 17'($urandom_range(1, c.min_pressure_pa - 1));
        end else if (pick >= 86 && pick < 91) begin
            it.req_type = REQ_REINIT;
            it.sensor_ok = $urandom_range(0, 1);
            it.now_ms = sb.read_time + $urandom_range(0, 400);
        end else if (pick >= 91) begin
            it = sample_t'(91'({$urandom, $urandom, $urandom}));
        end
        return it;
    endfunction

    task automatic send_item(input sample_t it);
        while ($urandom_range(0, 99) < ((send_count % 100 < 20) ? 0 : send_idle_pct)) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, it.altitude_cm, it.temperature_centi, it.pressure_pa,
                    it.trigger_ok, it.sensor_ok, it.now_ms};
        s_tuser <= it.req_type;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.note_input(it);
        send_count++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge aclk);
        while (sb.pending() != 0);
    endtask

    task automatic load_config(input cfg_t c);
        logic [CFG_IDX_W-1:0] idx_list[6] = '{CFG_MIN_PRESSURE, CFG_MAX_PRESSURE, CFG_MAX_RATE,
                                              CFG_GATE_DT_MAX, CFG_REJECT_LIMIT,
                                              CFG_SAMPLE_INTERVAL};
        wait_drained();
        foreach (idx_list[i]) begin
            cfg_we <= 1'b1;
            cfg_index <= idx_list[i];
            cfg_wdata <= reg_value(c, idx_list[i]);
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        sb.set_config(c);
    endtask

    task automatic run_phase(input cfg_t c, input int sidle, input int rstall, input int n,
                             input bit pause_midway);
        load_config(c);
        send_idle_pct = sidle;
        recv_stall_pct = rstall;
        for (int i = 0; i < n; i++) begin
            if (pause_midway && i == n / 2)
                wait_drained();
            send_item(gen_random());
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_item(mk(REQ_SAMPLE, 32'd1000, 1'b0, 1'b1, 50000, 2500, 1000));
        send_item(mk(REQ_REINIT, 32'd5, 1'b0, 1'b0, 0, 0, 0));
        send_item(mk(REQ_SAMPLE, 32'd10, 1'b1, 1'b1, 50000, 0, 0));
        send_item(mk(REQ_SAMPLE, 32'd50, 1'b1, 1'b0, 50000, 0, 0));
        send_item(mk(REQ_SAMPLE, 32'd100, 1'b1, 1'b1, 0, 0, 0));
        send_item(mk(REQ_SAMPLE, 32'd150, 1'b1, 1'b1, 29999, 0, 0));
        send_item(mk(REQ_SAMPLE, 32'd200, 1'b1, 1'b1, 131071, 0, 0));
        send_item(mk(REQ_SAMPLE, 32'd250, 1'b1, 1'b1, 30000, -4000, -100000));
        send_item(mk(REQ_SAMPLE, 32'd300, 1'b1, 1'b1, 110000, 8500, -97500));
        send_item(mk(REQ_SAMPLE, 32'd350, 1'b1, 1'b1, 60000, 100, -94999));
        send_item(mk(REQ_SAMPLE, 32'd400, 1'b1, 1'b1, 60000, 200, 5000000));
        send_item(mk(REQ_SAMPLE, 32'd450, 1'b1, 1'b1, 60000, 300, 5000000));
        send_item(mk(REQ_SAMPLE, 32'd500, 1'b1, 1'b1, 60000, 400, 5000000));
        send_item(mk(REQ_SAMPLE, 32'd550, 1'b1, 1'b1, 60000, 500, 5000000));
        send_item(mk(REQ_SAMPLE, 32'd600, 1'b1, 1'b1, 60000, 600, 4999000));
        send_item(mk(REQ_REINIT, 32'd650, 1'b1, 1'b1, 60000, 0, 0));
        send_item(mk(REQ_SAMPLE, 32'd700, 1'b1, 1'b1, 70000, -16384, -8388608));
        send_item(mk(REQ_SAMPLE, 32'hFFFF_FFF0, 1'b1, 1'b1, 70000, 16383, 8388607));
        send_item(mk(REQ_SAMPLE, 32'h0000_0020, 1'b1, 1'b1, 70000, 0, 0));
        send_item(mk(REQ_SAMPLE, 32'h0000_0022, 1'b1, 1'b1, 70000, 0, -8388600));
        send_item(mk(REQ_SAMPLE, 32'h0000_0060, 1'b1, 1'b1, 70000, 0, -8388599));

        run_phase('{17'd30000, 17'd110000, 20'd50000, 16'd500, 8'd5, 16'd50}, 0, 0, 300, 0);
        run_phase('{17'd0, 17'h1FFFF, 20'd1000000, 16'hFFFF, 8'd255, 16'd0}, 52, 0, 300, 0);
        run_phase('{17'h1FFFF, 17'd0, 20'd0, 16'd0, 8'd1, 16'hFFFF}, 0, 52, 200, 0);
        run_phase('{17'd50000, 17'd100000, 20'hFFFFF, 16'd1000, 8'd0, 16'd10}, 25, 25, 300, 0);
        run_phase('{17'd80000, 17'd80000, 20'd100, 16'd20, 8'd3, 16'd1}, 0, 0, 300, 1);
        run_phase('{17'd30000, 17'd110000, 20'd50000, 16'd500, 8'd5, 16'd50}, 25, 25, 350, 0);

        wait_drained();
        repeat (8) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
